// ----- hw/rtl/hrp_pkg.sv -----
// Shared types, constants and character tables of the HTTP response parser.
package hrp_pkg;

	localparam int LENGTH_WIDTH = 32;
	localparam int CODE_WIDTH   = 16;
	localparam int TICK_WIDTH   = 32;

	localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = '1;
	localparam logic [CODE_WIDTH-1:0]   CODE_MAX = '1;
	localparam logic [TICK_WIDTH-1:0]   TICK_MAX = '1;
	localparam logic [TICK_WIDTH-1:0]   TIMEOUT_RESET = TICK_WIDTH'(5000);

	localparam logic [2:0] ACT_START = 3'd0;
	localparam logic [2:0] ACT_DATA  = 3'd1;
	localparam logic [2:0] ACT_CLOSE = 3'd2;
	localparam logic [2:0] ACT_ERROR = 3'd3;
	localparam logic [2:0] ACT_TICK  = 3'd4;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_STATUS  = 2'd1;
	localparam logic [1:0] PH_HEADERS = 2'd2;
	localparam logic [1:0] PH_BODY    = 2'd3;

	localparam logic [4:0] M_START      = 5'd0;
	localparam logic [4:0] M_ST_WORD    = 5'd4;
	localparam logic [4:0] M_ST_SPACE   = 5'd5;
	localparam logic [4:0] M_ST_DIGITS  = 5'd6;
	localparam logic [4:0] M_ST_END     = 5'd7;
	localparam logic [4:0] M_HD_NAME    = 5'd14;
	localparam logic [4:0] M_HD_COLON   = 5'd15;
	localparam logic [4:0] M_HD_DIGITS  = 5'd16;
	localparam logic [4:0] M_HD_END     = 5'd17;
	localparam logic [4:0] M_DEAD       = 5'd31;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [CODE_WIDTH-1:0] CODE_CLOSED = CODE_WIDTH'(500);
	localparam logic [CODE_WIDTH-1:0] CODE_ERROR  = CODE_WIDTH'(504);
	localparam logic [CODE_WIDTH-1:0] CODE_TIMEOUT = CODE_WIDTH'(500);

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] data_byte;
		logic       chunk_last;
	} in_item_t;

	typedef struct packed {
		logic        body_valid;
		logic [7:0]  body_byte;
		logic        done_res;
		logic [15:0] status_code;
		logic [31:0] content_length;
	} res_item_t;

	function automatic logic [7:0] status_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0: ch = 8'h48;
			2'd1: ch = 8'h54;
			2'd2: ch = 8'h54;
			default: ch = 8'h50;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] name_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:  ch = 8'h43;
			4'd1:  ch = 8'h6f;
			4'd2:  ch = 8'h6e;
			4'd3:  ch = 8'h74;
			4'd4:  ch = 8'h65;
			4'd5:  ch = 8'h6e;
			4'd6:  ch = 8'h74;
			4'd7:  ch = 8'h2d;
			4'd8:  ch = 8'h4c;
			4'd9:  ch = 8'h65;
			4'd10: ch = 8'h6e;
			4'd11: ch = 8'h67;
			4'd12: ch = 8'h74;
			4'd13: ch = 8'h68;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ----- hw/rtl/hrp_in_stage.sv -----
// Input register of the HTTP response parser with its stall logic.
module hrp_in_stage import hrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	input  logic       advance,
	output logic       fire,
	output in_item_t   item_s1
);

	logic valid_s1;

	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- hw/rtl/hrp_parse_core.sv -----
// Parse state registers and the per-item state update of the HTTP response parser.
module hrp_parse_core import hrp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [TICK_WIDTH-1:0] cfg_wr_data,
	input  logic                  fire,
	input  in_item_t              item,
	output res_item_t             res
);

	logic [1:0]              phase_q, phase_n;
	logic [4:0]              matcher_q, matcher_n;
	logic                    empty_q, empty_n;
	logic                    skip_q, skip_n;
	logic [CODE_WIDTH-1:0]   code_q, code_n;
	logic [LENGTH_WIDTH-1:0] len_q, len_n;
	logic [LENGTH_WIDTH-1:0] cnt_q, cnt_n;
	logic [TICK_WIDTH-1:0]   elapsed_q, elapsed_n;
	logic [TICK_WIDTH-1:0]   timeout_q;

	logic [7:0]                c;
	logic [3:0]                digit;
	logic                      is_digit;
	logic [CODE_WIDTH+3:0]     code_ext;
	logic [CODE_WIDTH-1:0]     code_add;
	logic [LENGTH_WIDTH+3:0]   len_ext;
	logic [LENGTH_WIDTH-1:0]   len_add;
	logic [LENGTH_WIDTH-1:0]   cnt_inc;
	logic [TICK_WIDTH-1:0]     elapsed_inc;

	assign c        = item.data_byte;
	assign digit    = 4'(c - CH_ZERO);
	assign is_digit = c inside {[8'h30:8'h39]};

	always_comb begin
		code_ext = (CODE_WIDTH+4)'({code_q, 3'b0}) + (CODE_WIDTH+4)'({code_q, 1'b0})
			+ (CODE_WIDTH+4)'(digit);
		code_add = (code_ext > (CODE_WIDTH+4)'(CODE_MAX)) ? CODE_MAX : code_ext[CODE_WIDTH-1:0];
		len_ext  = (LENGTH_WIDTH+4)'({len_q, 3'b0}) + (LENGTH_WIDTH+4)'({len_q, 1'b0})
			+ (LENGTH_WIDTH+4)'(digit);
		len_add  = (len_ext > (LENGTH_WIDTH+4)'(LEN_MAX)) ? LEN_MAX : len_ext[LENGTH_WIDTH-1:0];
		cnt_inc     = (cnt_q < LEN_MAX) ? cnt_q + 1'b1 : cnt_q;
		elapsed_inc = (elapsed_q < TICK_MAX) ? elapsed_q + 1'b1 : elapsed_q;
	end

	always_comb begin
		phase_n   = phase_q;
		matcher_n = matcher_q;
		empty_n   = empty_q;
		skip_n    = skip_q;
		code_n    = code_q;
		len_n     = len_q;
		cnt_n     = cnt_q;
		elapsed_n = elapsed_q;
		res       = '0;
		if (fire) begin
			if (item.action == ACT_START) begin
				if (phase_q == PH_IDLE) begin
					phase_n   = PH_STATUS;
					matcher_n = M_START;
					empty_n   = 1'b1;
					skip_n    = 1'b0;
					code_n    = '0;
					len_n     = '0;
					cnt_n     = '0;
					elapsed_n = '0;
				end
			end else if (phase_q != PH_IDLE) begin
				case (item.action)
					ACT_DATA: begin
						skip_n = 1'b0;
						if (!(skip_q && c == CH_LF)) begin
							if (phase_q == PH_BODY) begin
								res.body_valid = 1'b1;
								res.body_byte  = c;
								cnt_n = cnt_inc;
								if (cnt_inc >= len_q) begin
									res.done_res       = 1'b1;
									res.status_code    = code_q;
									res.content_length = 32'(len_q);
									phase_n = PH_IDLE;
								end
							end else if (c == CH_CR) begin
								if (empty_q) begin
									if (len_q != '0) begin
										phase_n = PH_BODY;
										cnt_n   = '0;
									end else begin
										res.done_res       = 1'b1;
										res.status_code    = code_q;
										res.content_length = 32'(len_q);
										phase_n = PH_IDLE;
									end
								end else if (phase_q == PH_STATUS &&
									matcher_q >= M_ST_WORD && matcher_q <= M_ST_END) begin
									phase_n = PH_HEADERS;
								end
								matcher_n = M_START;
								empty_n   = 1'b1;
								skip_n    = !item.chunk_last;
							end else begin
								empty_n = 1'b0;
								if (phase_q == PH_STATUS) begin
									if (matcher_q < M_ST_WORD) begin
										if (c == status_char(matcher_q[1:0])) begin
											matcher_n = matcher_q + 1'b1;
											if (matcher_q == M_ST_WORD - 1'b1) begin
												code_n = '0;
											end
										end else begin
											matcher_n = M_DEAD;
										end
									end else if (matcher_q == M_ST_WORD) begin
										if (c == CH_SPACE) begin
											matcher_n = M_ST_SPACE;
										end
									end else if (matcher_q == M_ST_SPACE ||
										matcher_q == M_ST_DIGITS) begin
										if (matcher_q == M_ST_SPACE && c == CH_SPACE) begin
											matcher_n = matcher_q;
										end else if (is_digit) begin
											code_n    = code_add;
											matcher_n = M_ST_DIGITS;
										end else begin
											matcher_n = M_ST_END;
										end
									end
								end else begin
									if (matcher_q < M_HD_NAME) begin
										if (matcher_q == M_START && c == CH_SPACE) begin
											matcher_n = matcher_q;
										end else if (c == name_char(matcher_q[3:0])) begin
											matcher_n = matcher_q + 1'b1;
											if (matcher_q == M_HD_NAME - 1'b1) begin
												len_n = '0;
											end
										end else begin
											matcher_n = M_DEAD;
										end
									end else if (matcher_q == M_HD_NAME) begin
										if (c == CH_COLON) begin
											matcher_n = M_HD_COLON;
										end
									end else if (matcher_q == M_HD_COLON ||
										matcher_q == M_HD_DIGITS) begin
										if (matcher_q == M_HD_COLON && c == CH_SPACE) begin
											matcher_n = matcher_q;
										end else if (is_digit) begin
											len_n     = len_add;
											matcher_n = M_HD_DIGITS;
										end else begin
											matcher_n = M_HD_END;
										end
									end
								end
							end
						end
					end
					ACT_CLOSE, ACT_ERROR: begin
						code_n = (item.action == ACT_ERROR) ? CODE_ERROR : CODE_CLOSED;
						len_n  = '0;
						res.done_res    = 1'b1;
						res.status_code = code_n;
						phase_n = PH_IDLE;
					end
					ACT_TICK: begin
						elapsed_n = elapsed_inc;
						if (elapsed_inc >= timeout_q) begin
							code_n = CODE_TIMEOUT;
							res.done_res       = 1'b1;
							res.status_code    = CODE_TIMEOUT;
							res.content_length = 32'(len_q);
							phase_n = PH_IDLE;
						end
					end
					default: begin
						phase_n = phase_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			matcher_q <= M_START;
			empty_q   <= 1'b1;
			skip_q    <= 1'b0;
			code_q    <= '0;
			len_q     <= '0;
			cnt_q     <= '0;
			elapsed_q <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else begin
			phase_q   <= phase_n;
			matcher_q <= matcher_n;
			empty_q   <= empty_n;
			skip_q    <= skip_n;
			code_q    <= code_n;
			len_q     <= len_n;
			cnt_q     <= cnt_n;
			elapsed_q <= elapsed_n;
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
		end
	end

endmodule

// ----- hw/rtl/hrp_out_stage.sv -----
// Result register of the HTTP response parser.
module hrp_out_stage import hrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  res_item_t res,
	input  logic      out_stall,
	output logic      out_valid,
	output logic      advance,
	output res_item_t res_q
);

	logic valid_q;

	assign advance   = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			res_q <= res;
		end
	end

endmodule

// ----- hw/rtl/http_response_parser.sv -----
// Top level of the HTTP response parser.
// The parser takes one item per transfer: start, a response byte, connection closed,
// connection error or a timer tick, and returns exactly one result per item. An item
// is held in the input register, its parse-state update runs when it leaves it for
// the output register, and its result is registered there; one item can be taken every
// cycle while the output is not stalled. While a stalled result waits in the output
// register, the input register takes one more item and the input then stalls until
// that result is taken. Body bytes stream out with
// body_valid set; done_res marks the result that finishes a response, with the status
// code and length, and the timeout register may be written only while no item is in flight.
module http_response_parser import hrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [7:0]  data_byte,
	input  logic        chunk_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        body_valid,
	output logic [7:0]  body_byte,
	output logic        done_res,
	output logic [15:0] status_code,
	output logic [31:0] content_length
);

	in_item_t  in_item;
	in_item_t  item_s1;
	res_item_t res;
	res_item_t res_q;
	logic      advance;
	logic      fire;

	assign in_item.action     = action;
	assign in_item.data_byte  = data_byte;
	assign in_item.chunk_last = chunk_last;

	hrp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	hrp_parse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.item        (item_s1),
		.res         (res)
	);

	hrp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.advance   (advance),
		.res_q     (res_q)
	);

	assign body_valid     = res_q.body_valid;
	assign body_byte      = res_q.body_byte;
	assign done_res       = res_q.done_res;
	assign status_code    = res_q.status_code;
	assign content_length = res_q.content_length;

endmodule

// ----- hw/rtl/hrp_checker.sv -----
// Port-level checker of the HTTP response parser and its bind to the top level.
module hrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic [31:0] cfg_wr_data,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  action,
	input logic [7:0]  data_byte,
	input logic        chunk_last,
	input logic        out_valid,
	input logic        out_stall,
	input logic        body_valid,
	input logic [7:0]  body_byte,
	input logic        done_res,
	input logic [15:0] status_code,
	input logic [31:0] content_length
);

	// A stalled result must hold until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(body_valid) && $stable(body_byte)
			&& $stable(done_res) && $stable(status_code) && $stable(content_length))
		else $error("stalled result changed");

	// The input side only stalls while a result is held back by the output side.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	// An accepted item shows its result once the output is free.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("result missing after transfer");

	// Results that do not finish a response carry no code and no length.
	a_not_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status_code == 16'd0 && content_length == 32'd0)
		else $error("code or length on a result that does not finish");

	// A result without a body byte carries a zero byte.
	a_no_body_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !body_valid |-> body_byte == 8'd0)
		else $error("body byte set without body_valid");

endmodule

bind http_response_parser hrp_checker u_chk (.*);

// ----- sim/http_response_parser_tb.sv -----
// Self-checking testbench for the HTTP response parser with a built-in parse predictor.
module http_response_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hrp_pkg::*;

	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
	localparam logic [31:0] STATUS_TXT = "HTTP";
	localparam logic [8*14-1:0] NAME_TXT = "Content-Length";

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] action = ACT_TICK;
	logic [7:0] data_byte = '0;
	logic chunk_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic body_valid;
	logic [7:0] body_byte;
	logic done_res;
	logic [15:0] status_code;
	logic [31:0] content_length;

	http_response_parser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.data_byte(data_byte),
		.chunk_last(chunk_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.body_valid(body_valid),
		.body_byte(body_byte),
		.done_res(done_res),
		.status_code(status_code),
		.content_length(content_length)
	);

	in_item_t queued_actions[$];
	res_item_t parse_results_due[$];
	in_item_t next_item;
	res_item_t due;
	logic in_fire = 1'b0;
	int mismatch_count = 0;
	int items_made = 0;
	bit stray_lf = 1'b0;

	logic [1:0] phase_q = PH_IDLE;
	logic [4:0] matcher_q = M_START;
	logic empty_q = 1'b1;
	logic skip_lf_q = 1'b0;
	logic [15:0] code_q = '0;
	logic [31:0] length_q = '0;
	logic [31:0] count_q = '0;
	logic [31:0] ticks_q = '0;
	logic [31:0] timeout_q = TIMEOUT_RESET;

	int burst_left = 0;
	int gap_left = 0;
	int stall_run = 0;
	int stall_mode = 0;
	int mode_left = 0;
	logic stall_next;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic in_item_t make_item(logic [2:0] act, logic [7:0] b, logic last);
		in_item_t it;
		it.action = act;
		it.data_byte = b;
		it.chunk_last = last;
		return it;
	endfunction

	function automatic void mark_done(inout res_item_t r, input logic [15:0] code,
			input logic [31:0] len);
		r.done_res = 1'b1;
		r.status_code = code;
		r.content_length = len;
		phase_q = PH_IDLE;
	endfunction

	function automatic res_item_t predict_parse_step(in_item_t it);
		res_item_t r;
		logic [7:0] c;
		logic [63:0] wide;
		int idx;
		r = '0;
		c = it.data_byte;
		if (it.action == ACT_START) begin
			if (phase_q == PH_IDLE) begin
				phase_q = PH_STATUS;
				matcher_q = M_START;
				empty_q = 1'b1;
				skip_lf_q = 1'b0;
				code_q = '0;
				length_q = '0;
				count_q = '0;
				ticks_q = '0;
			end
			return r;
		end
		if (phase_q == PH_IDLE)
			return r;
		case (it.action)
			ACT_CLOSE, ACT_ERROR: begin
				code_q = (it.action == ACT_ERROR) ? CODE_ERROR : CODE_CLOSED;
				length_q = '0;
				mark_done(r, code_q, '0);
			end
			ACT_TICK: begin
				if (ticks_q != TICK_MAX)
					ticks_q++;
				if (ticks_q >= timeout_q) begin
					code_q = CODE_TIMEOUT;
					mark_done(r, code_q, length_q);
				end
			end
			ACT_DATA: begin
				if (skip_lf_q) begin
					skip_lf_q = 1'b0;
					if (c == CH_LF)
						return r;
				end
				if (phase_q == PH_BODY) begin
					r.body_valid = 1'b1;
					r.body_byte = c;
					if (count_q != LEN_MAX)
						count_q++;
					if (count_q >= length_q)
						mark_done(r, code_q, length_q);
				end else if (c == CH_CR) begin
					if (empty_q) begin
						if (length_q != '0) begin
							phase_q = PH_BODY;
							count_q = '0;
						end else begin
							mark_done(r, code_q, length_q);
						end
					end else if (phase_q == PH_STATUS && matcher_q >= M_ST_WORD
							&& matcher_q <= M_ST_END) begin
						phase_q = PH_HEADERS;
					end
					matcher_q = M_START;
					empty_q = 1'b1;
					skip_lf_q = !it.chunk_last;
				end else begin
					empty_q = 1'b0;
					idx = matcher_q;
					if (phase_q == PH_STATUS) begin
						if (matcher_q < M_ST_WORD) begin
							if (c == STATUS_TXT[8*(3-idx) +: 8]) begin
								matcher_q++;
								if (matcher_q == M_ST_WORD)
									code_q = '0;
							end else begin
								matcher_q = M_DEAD;
							end
						end else if (matcher_q == M_ST_WORD) begin
							if (c == CH_SPACE)
								matcher_q = M_ST_SPACE;
						end else if (matcher_q == M_ST_SPACE || matcher_q == M_ST_DIGITS) begin
							if (matcher_q == M_ST_SPACE && c == CH_SPACE) begin
							end else if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
								wide = 64'(code_q) * 64'd10 + 64'(c - CH_ZERO);
								code_q = (wide > 64'(CODE_MAX)) ? CODE_MAX : wide[15:0];
								matcher_q = M_ST_DIGITS;
							end else begin
								matcher_q = M_ST_END;
							end
						end
					end else begin
						if (matcher_q < M_HD_NAME) begin
							if (matcher_q == M_START && c == CH_SPACE) begin
							end else if (c == NAME_TXT[8*(13-idx) +: 8]) begin
								matcher_q++;
								if (matcher_q == M_HD_NAME)
									length_q = '0;
							end else begin
								matcher_q = M_DEAD;
							end
						end else if (matcher_q == M_HD_NAME) begin
							if (c == CH_COLON)
								matcher_q = M_HD_COLON;
						end else if (matcher_q == M_HD_COLON || matcher_q == M_HD_DIGITS) begin
							if (matcher_q == M_HD_COLON && c == CH_SPACE) begin
							end else if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
								wide = 64'(length_q) * 64'd10 + 64'(c - CH_ZERO);
								length_q = (wide > 64'(LEN_MAX)) ? LEN_MAX : wide[31:0];
								matcher_q = M_HD_DIGITS;
							end else begin
								matcher_q = M_HD_END;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < 40)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic push_item(logic [2:0] act, logic [7:0] b, logic last);
		queued_actions.push_back(make_item(act, b, last));
		items_made++;
	endtask

	task automatic push_line(string s, bit plain);
		bit cut;
		for (int i = 0; i < s.len(); i++) begin
			if (!plain && $urandom_range(0, 39) == 0)
				push_item(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			else if (!plain && $urandom_range(0, 59) == 0)
				push_item(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			push_item(ACT_DATA, s[i], !plain && $urandom_range(0, 15) == 0);
		end
		cut = !plain && $urandom_range(0, 9) == 0;
		push_item(ACT_DATA, CH_CR, cut);
		if (plain || $urandom_range(0, 7) != 0) begin
			push_item(ACT_DATA, CH_LF, 1'($urandom_range(0, 1)));
			if (cut)
				stray_lf = 1'b1;
		end
	endtask

	task automatic gen_response();
		int body_len;
		int sent;
		bit unsure;
		string s;
		string lead;
		unsure = 1'b0;
		stray_lf = 1'b0;
		body_len = 0;
		if ($urandom_range(0, 5) == 0)
			queued_actions.push_back(make_item(3'($urandom_range(ACT_DATA, ACT_UNUSED_HI)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
		push_item(ACT_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 9) == 0)
			push_item(ACT_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 7) == 0)
			push_line("garbage line", 1'b0);
		case ($urandom_range(0, 9))
			0: s = "HTTP/1.0  99999999";
			1: s = $sformatf("HTTP/1.1 %0d", $urandom_range(65534, 65536));
			2: s = "HTTP/1.1 abc";
			3: s = "HTTX/1.1 200 OK";
			4: s = "HTTP";
			default: s = $sformatf("HTTP/1.1 %0d OK", $urandom_range(100, 599));
		endcase
		push_line(s, 1'b0);
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 7))
				0: push_line("Server: unit", 1'b0);
				1: begin
					body_len = 0;
					push_line("Content-Length 12", 1'b0);
				end
				2: begin
					unsure = 1'b1;
					body_len = $urandom_range(0, 4);
					push_line($urandom_range(0, 1) ? "  Content-Length: 99999999999"
						: "Content-Length: 4294967295", 1'b0);
				end
				3: push_line("Content-length: 5", 1'b0);
				4: begin
					body_len = 0;
					push_line("Content-Length:x7", 1'b0);
				end
				default: begin
					body_len = $urandom_range(0, 12);
					lead = "";
					repeat ($urandom_range(0, 2))
						lead = {lead, " "};
					push_line($sformatf("%sContent-Length:%s%0d", lead, lead, body_len), 1'b0);
				end
			endcase
		end
		push_line("", 1'b0);
		sent = body_len;
		if ($urandom_range(0, 5) == 0) begin
			sent = $urandom_range(0, body_len);
			unsure = 1'b1;
		end
		repeat (sent)
			push_item(ACT_DATA, 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		if (unsure || stray_lf || $urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 2))
				0: push_item(ACT_CLOSE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				1: push_item(ACT_ERROR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				default: begin
					if (timeout_q <= 64)
						repeat (timeout_q)
							push_item(ACT_TICK, 8'($urandom_range(0, 255)),
								1'($urandom_range(0, 1)));
					else
						push_item(ACT_CLOSE, 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
				end
			endcase
		end
	endtask

	task automatic run_phase(int count);
		int target;
		target = items_made + count;
		while (items_made < target)
			gen_response();
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (queued_actions.size() != 0 || in_valid || parse_results_due.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_timeout(logic [31:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		timeout_q = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (queued_actions.size() != 0) begin
				next_item = queued_actions.pop_front();
				in_valid <= 1'b1;
				action <= next_item.action;
				data_byte <= next_item.data_byte;
				chunk_last <= next_item.chunk_last;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		if (stall_run != 0) begin
			stall_run--;
			stall_next = 1'b1;
		end else begin
			case (stall_mode)
				0: stall_next = 1'b0;
				1: stall_next = ($urandom_range(0, 3) == 0);
				default: begin
					stall_next = ($urandom_range(0, 9) == 0);
					if (stall_next)
						stall_run = $urandom_range(1, 10);
				end
			endcase
		end
		out_stall <= stall_next;
	end

	always @(posedge clk) begin
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (parse_results_due.size() == 0) begin
					report_mismatch("result transfer with nothing outstanding");
				end else begin
					due = parse_results_due.pop_front();
					if (body_valid !== due.body_valid)
						report_mismatch($sformatf("body_valid got %0d want %0d",
							body_valid, due.body_valid));
					if (body_byte !== due.body_byte)
						report_mismatch($sformatf("body_byte got %0h want %0h",
							body_byte, due.body_byte));
					if (done_res !== due.done_res)
						report_mismatch($sformatf("done_res got %0d want %0d",
							done_res, due.done_res));
					if (status_code !== due.status_code)
						report_mismatch($sformatf("status_code got %0d want %0d",
							status_code, due.status_code));
					if (content_length !== due.content_length)
						report_mismatch($sformatf("content_length got %0d want %0d",
							content_length, due.content_length));
				end
			end
			if (in_valid && !in_stall)
				parse_results_due.push_back(predict_parse_step(make_item(action, data_byte,
					chunk_last)));
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		push_item(ACT_DATA, 8'h48, 1'b0);
		push_item(ACT_CLOSE, 8'h00, 1'b0);
		push_item(ACT_TICK, 8'h00, 1'b0);
		push_item(ACT_UNUSED_HI, 8'hff, 1'b1);
		push_item(ACT_START, 8'h00, 1'b0);
		push_item(ACT_START, 8'hff, 1'b1);
		push_item(ACT_UNUSED_LO, 8'h00, 1'b0);
		push_item(ACT_TICK, 8'h00, 1'b0);
		push_item(ACT_DATA, 8'hff, 1'b0);
		push_item(ACT_DATA, 8'h00, 1'b1);
		push_item(ACT_ERROR, 8'h00, 1'b0);
		push_item(ACT_DATA, CH_CR, 1'b0);
		push_item(ACT_START, 8'h00, 1'b0);
		push_item(ACT_DATA, CH_CR, 1'b0);
		push_item(ACT_DATA, CH_LF, 1'b0);
		push_item(ACT_START, 8'h00, 1'b0);
		push_item(ACT_CLOSE, 8'hff, 1'b1);
		push_item(ACT_START, 8'h00, 1'b0);
		push_line("HTTP 7", 1'b1);
		push_line("", 1'b1);
		run_phase(150);
		wait_idle();

		write_timeout(32'd1);
		push_item(ACT_START, 8'h00, 1'b0);
		push_item(ACT_TICK, 8'h00, 1'b0);
		run_phase(120);
		wait_idle();

		write_timeout(TICK_MAX);
		run_phase(170);
		wait_idle();

		write_timeout(32'd3);
		run_phase(170);
		wait_idle();

		write_timeout($urandom_range(4, 60));
		run_phase(170);
		wait_idle();
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
